// ----- rtl/huffman_code_bit_packer_defines.svh -----
// Assertion macros shared by the Huffman code bit packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define HCBP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hcbp: property violated");

// Check that a condition in one cycle implies a consequence in the next.
`define HCBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcbp: next-cycle property violated");

`endif

// ----- rtl/hcbp_pkg.sv -----
// Package: types, opcodes and constants of the Huffman code bit packer.
`default_nettype none

package hcbp_pkg;

   // longest code word the table holds by default
   localparam int DEF_MAX_CODE_LEN = 16;

   // table depth and index width
   localparam int TABLE_DEPTH = 256;
   localparam int SYM_W       = 8;

   // packing window: one pending byte plus the longest code
   localparam int WIN_W = 24;
   localparam int SH_W  = 5;

   // result queue
   localparam int FIFO_DEPTH = 4;

   // opcodes
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_ENCODE = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  symbol;
      logic [15:0] code_bits;
      logic [4:0]  code_length;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] padding_bits;
      logic       is_last;
   } rsp_item_type;

   // results handed from the packer to the result queue in the same cycle
   typedef struct packed {
      logic [1:0]   num;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

endpackage

`default_nettype wire

// ----- rtl/huffman_code_bit_packer.sv -----
// Top level of the Huffman code bit packer.
`default_nettype none

// Packs Huffman code words, most significant bit first, into bytes. Each
// request is a table write, a symbol to encode or a flush. A request is taken
// when it arrives unless the packer stalls; the code table is read into a
// register and, once the result queue has room for two results, the packer
// merges that code with the pending bits and hands zero, one or two bytes to
// a four-entry result queue. One request a cycle is sustained while results
// average at most one per request and rsp_stall stays low; the single result
// port, one byte a cycle, sets the limit when codes yield two bytes. A flush
// returns the partial byte with its padding count and yields nothing when no
// bits are pending. Encoding a symbol never written gives undefined bytes.
module huffman_code_bit_packer
   import hcbp_pkg::*;
#(
   parameter  int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
   localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire req_item_type req_item,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      rsp_item_type rsp_item
);

   logic                    accept;
   logic                    space_ok;
   logic [MAX_CODE_LEN-1:0] rd_word;
   logic [LEN_W-1:0]        rd_len;
   push_type                push;

   assign accept = req_valid && !req_stall;

   // table access on each accepted transfer
   hcbp_code_table #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_code_table (
      .clock      (clock),
      .wr_en      (accept && (req_item.opcode == OP_WRITE)),
      .wr_addr    (req_item.symbol),
      .wr_word    (req_item.code_bits),
      .wr_len     (req_item.code_length),
      .rd_en      (accept),
      .rd_addr    (req_item.symbol),
      .rd_word_ff (rd_word),
      .rd_len_ff  (rd_len)
   );

   // merge codes into bytes
   hcbp_packer #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_packer (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .opcode   (req_item.opcode),
      .rd_word  (rd_word),
      .rd_len   (rd_len),
      .space_ok (space_ok),
      .stall    (req_stall),
      .push     (push)
   );

   // queue results towards the output
   hcbp_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ----- rtl/hcbp_code_table.sv -----
// Code table memory: one code word and saturated length per symbol.
`default_nettype none

module hcbp_code_table
   import hcbp_pkg::*;
#(
   parameter  int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
   localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [SYM_W-1:0]        wr_addr,
   input  wire logic [15:0]             wr_word,
   input  wire logic [4:0]              wr_len,
   input  wire logic                    rd_en,
   input  wire logic [SYM_W-1:0]        rd_addr,
   output      logic [MAX_CODE_LEN-1:0] rd_word_ff,
   output      logic [LEN_W-1:0]        rd_len_ff
);

   logic [MAX_CODE_LEN-1:0] word_mem [TABLE_DEPTH];
   logic [LEN_W-1:0]        len_mem  [TABLE_DEPTH];
   logic [LEN_W-1:0]        wr_len_sat;

   // clamp long lengths once, on the way in
   always_comb begin
      if (wr_len > 5'(MAX_CODE_LEN)) begin
         wr_len_sat = LEN_W'(MAX_CODE_LEN);
      end else begin
         wr_len_sat = LEN_W'(wr_len);
      end
   end

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_mem[wr_addr] <= wr_word[MAX_CODE_LEN-1:0];
         len_mem[wr_addr]  <= wr_len_sat;
      end
   end

   // registered read port, held while no transfer is taken
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= word_mem[rd_addr];
         rd_len_ff  <= len_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hcbp_packer.sv -----
// Bit packer: pending byte state and byte assembly for encode and flush.
`default_nettype none
`include "huffman_code_bit_packer_defines.svh"

module hcbp_packer
   import hcbp_pkg::*;
#(
   parameter  int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
   localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic [1:0]              opcode,
   input  wire logic [MAX_CODE_LEN-1:0] rd_word,
   input  wire logic [LEN_W-1:0]        rd_len,
   input  wire logic                    space_ok,
   output      logic                    stall,
   output      push_type                push
);

   logic                    s1_valid_ff, s1_valid_in;
   logic [1:0]              op_ff;
   logic [7:0]              pend_byte_ff, pend_byte_in;
   logic [2:0]              pend_cnt_ff, pend_cnt_in;
   logic                    fire;
   logic [MAX_CODE_LEN-1:0] code_masked;
   logic [WIN_W-1:0]        win_code;
   logic [WIN_W-1:0]        acc;
   logic [SH_W-1:0]         total;
   logic [SH_W-1:0]         shift;
   logic [1:0]              nbytes;
   logic [2:0]              pad;

   // an item leaves the stage when the queue has room for two results
   assign fire  = s1_valid_ff && space_ok;
   assign stall = s1_valid_ff && !space_ok;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= opcode;
      end
   end

   // line the new code up directly after the pending bits
   assign code_masked = rd_word & ~({MAX_CODE_LEN{1'b1}} << rd_len);
   assign win_code    = {{(WIN_W - MAX_CODE_LEN){1'b0}}, code_masked};
   assign total       = {2'b00, pend_cnt_ff} + SH_W'(rd_len);
   assign shift       = SH_W'(WIN_W) - total;
   assign acc         = {pend_byte_ff, {(WIN_W - 8){1'b0}}} | (win_code << shift);
   assign nbytes      = total[4:3];
   assign pad         = 3'(4'd8 - {1'b0, pend_cnt_ff});

   // results and next pending state
   always_comb begin
      push.num     = 2'd0;
      push.first   = '{out_byte: acc[23:16], padding_bits: 3'd0,
                       is_last: (nbytes == 2'd1)};
      push.second  = '{out_byte: acc[15:8], padding_bits: 3'd0, is_last: 1'b1};
      pend_byte_in = pend_byte_ff;
      pend_cnt_in  = pend_cnt_ff;
      case (op_ff)
         OP_ENCODE: begin
            if (fire) begin
               push.num    = nbytes;
               pend_cnt_in = total[2:0];
               case (nbytes)
                  2'd0:    pend_byte_in = acc[23:16];
                  2'd1:    pend_byte_in = acc[15:8];
                  default: pend_byte_in = acc[7:0];
               endcase
            end
         end
         OP_FLUSH: begin
            push.first = '{out_byte: pend_byte_ff, padding_bits: pad, is_last: 1'b1};
            if (fire && (pend_cnt_ff != 3'd0)) begin
               push.num     = 2'd1;
               pend_byte_in = 8'd0;
               pend_cnt_in  = 3'd0;
            end
         end
         default: begin
            push.num = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_byte_ff <= 8'd0;
         pend_cnt_ff  <= 3'd0;
      end else begin
         pend_byte_ff <= pend_byte_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   // a flush leaves nothing pending
   `HCBP_ASSERT_NEXT(a_flush_clears, clock, reset, fire && (op_ff == OP_FLUSH), pend_cnt_ff == 3'd0)
   // results only come from an item that leaves the stage
   `HCBP_ASSERT(a_push_needs_fire, clock, reset, (push.num == 2'd0) || fire)
   // two bytes only from an encode
   `HCBP_ASSERT(a_two_only_encode, clock, reset, (push.num != 2'd2) || (op_ff == OP_ENCODE))

endmodule

`default_nettype wire

// ----- rtl/hcbp_result_fifo.sv -----
// Result queue: takes up to two results a cycle, delivers one a cycle unless stalled.
`default_nettype none
`include "huffman_code_bit_packer_defines.svh"

module hcbp_result_fifo
   import hcbp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire push_type     push,
   output      logic         space_ok,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      rsp_item_type rsp_item
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   rsp_item_type     entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign space_ok  = count_ff <= CNT_W'(FIFO_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   // advance pointers and fill level
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.num);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.num) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed results in order
   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

   // never overfill
   `HCBP_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(FIFO_DEPTH))
   // results are pushed only when two slots are free
   `HCBP_ASSERT(a_push_has_room, clock, reset, (push.num == 2'd0) || space_ok)

endmodule

`default_nettype wire

// ----- bench/huffman_code_bit_packer_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the Huffman code bit packer: table writes, encodes and flushes.
module huffman_code_bit_packer_test;
   import hcbp_pkg::*;

   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam int         LIMIT_CYCLES  = 1000000;
   localparam int         RANDOM_ITEMS  = 1500;
   localparam int         SETTLE_CYCLES = 20;
   localparam int         DRAIN_EVERY   = 500;

   typedef struct {
      req_item_type item;
      bit           drain;
   } queued_req_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   // requests waiting to be offered, and bytes still owed by the block
   queued_req_type pending_reqs[$];
   rsp_item_type   expected_bytes[$];

   // predicted block state
   logic [15:0] code_words[256];
   logic [4:0]  code_lengths[256];
   logic [7:0]  partial_byte  = 8'h00;
   logic [2:0]  partial_count = 3'd0;

   // generator bookkeeping: only written entries may be encoded
   bit written[256];
   int written_syms[$];
   bit drain_due = 1'b0;

   int mismatch_count = 0;
   int cycle_count    = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   bit send_quiet     = 1'b0;
   bit recv_quiet     = 1'b0;

   huffman_code_bit_packer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #10 clock = ~clock;

   // Mostly short gaps, a few long ones; none in a quiet stretch.
   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Update the predicted state for one accepted request and queue its bytes.
   task automatic pack_request(input req_item_type r);
      int           len;
      int           fill;
      int           total;
      int           nbytes;
      logic [31:0]  code;
      logic [31:0]  window;
      rsp_item_type res;
      case (r.opcode)
         OP_WRITE: begin
            code_words[r.symbol]   = r.code_bits;
            code_lengths[r.symbol] = r.code_length;
         end
         OP_ENCODE: begin
            len = code_lengths[r.symbol];
            if (len > DEF_MAX_CODE_LEN) len = DEF_MAX_CODE_LEN;
            fill = partial_count;
            code = {16'h0000, code_words[r.symbol]} & ((32'd1 << len) - 32'd1);
            // pending bits on top of a 24-bit window, new code straight after
            window = ({24'h000000, partial_byte} << 16) | (code << (24 - fill - len));
            total  = fill + len;
            nbytes = total / 8;
            for (int i = 0; i < nbytes; i++) begin
               res.out_byte     = 8'(window >> (16 - 8 * i));
               res.padding_bits = 3'd0;
               res.is_last      = (i + 1 == nbytes);
               expected_bytes.push_back(res);
            end
            partial_byte  = 8'(window >> (16 - 8 * nbytes));
            partial_count = 3'(total % 8);
         end
         OP_FLUSH: begin
            if (partial_count != 3'd0) begin
               res.out_byte     = partial_byte;
               res.padding_bits = 3'(8 - partial_count);
               res.is_last      = 1'b1;
               expected_bytes.push_back(res);
               partial_byte  = 8'h00;
               partial_count = 3'd0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic queue_req(input logic [1:0] op, input logic [7:0] sym,
                            input logic [15:0] bits, input logic [4:0] len);
      queued_req_type q;
      q.item.opcode      = op;
      q.item.symbol      = sym;
      q.item.code_bits   = bits;
      q.item.code_length = len;
      q.drain            = drain_due;
      drain_due          = 1'b0;
      pending_reqs.push_back(q);
   endtask

   task automatic queue_write(input logic [7:0] sym, input logic [15:0] bits,
                              input logic [4:0] len);
      if (!written[sym]) begin
         written[sym] = 1'b1;
         written_syms.push_back(sym);
      end
      queue_req(OP_WRITE, sym, bits, len);
   endtask

   // Code lengths: mostly legal, some zero, a few above the longest code.
   function automatic logic [4:0] random_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 5'd0;
      if (r < 10) return 5'($urandom_range(17, 31));
      if (r < 25) return 5'd16;
      return 5'($urandom_range(1, 16));
   endfunction

   // Offer requests from the queue, with gaps between transfers.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pack_request(req_item);
            if ($urandom_range(0, 199) == 0) send_quiet = ~send_quiet;
         end
         if (req_valid && req_stall) begin
            // hold the stalled transfer as it is
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0 &&
                      !(pending_reqs[0].drain && expected_bytes.size() != 0)) begin
            req_item  <= pending_reqs[0].item;
            req_valid <= 1'b1;
            void'(pending_reqs.pop_front());
            send_gap = pick_gap(send_quiet);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Check each result transfer against the oldest expected byte; stall at random.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected result, expected none, got byte %02h pad %0d last %0b",
                        $time, rsp_item.out_byte, rsp_item.padding_bits, rsp_item.is_last);
               mismatch_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_item.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte mismatch, expected %02h, got %02h",
                           $time, want.out_byte, rsp_item.out_byte);
                  mismatch_count++;
               end
               if (rsp_item.padding_bits !== want.padding_bits) begin
                  $display("%0t: padding_bits mismatch, expected %0d, got %0d",
                           $time, want.padding_bits, rsp_item.padding_bits);
                  mismatch_count++;
               end
               if (rsp_item.is_last !== want.is_last) begin
                  $display("%0t: is_last mismatch, expected %0b, got %0b",
                           $time, want.is_last, rsp_item.is_last);
                  mismatch_count++;
               end
            end
         end
         if ($urandom_range(0, 299) == 0) recv_quiet = ~recv_quiet;
         if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap(recv_quiet);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("huffman_code_bit_packer test failed");
         $finish;
      end
   end

   initial begin
      int n;
      int k;
      int r;
      int next_drain;

      // Directed: table extremes, zero and long lengths, stray code bits
      queue_write(8'd0,   16'h0000, 5'd1);
      queue_write(8'd255, 16'hFFFF, 5'd16);
      queue_write(8'd1,   16'hA5C3, 5'd16);
      queue_write(8'd2,   16'hFFFF, 5'd0);
      queue_write(8'd3,   16'hFFFF, 5'd3);
      queue_write(8'd4,   16'h1234, 5'd31);
      queue_write(8'd5,   16'h5555, 5'd17);
      queue_write(8'd6,   16'hFF2A, 5'd7);
      queue_write(8'd7,   16'hC3A5, 5'd8);
      // flush with nothing pending, two-byte spill, zero-length symbol
      queue_req(OP_FLUSH,  8'd0,   16'hFFFF, 5'd31);
      queue_req(OP_ENCODE, 8'd3,   16'h0000, 5'd0);
      queue_req(OP_ENCODE, 8'd255, 16'h0000, 5'd0);
      queue_req(OP_ENCODE, 8'd2,   16'h0000, 5'd0);
      queue_req(OP_FLUSH,  8'd0,   16'h0000, 5'd0);
      queue_req(OP_FLUSH,  8'd0,   16'h0000, 5'd0);
      queue_req(OP_UNUSED, 8'hFF,  16'hFFFF, 5'd31);
      // 7 + 16 bits leaves 7 pending, one more bit completes a byte
      queue_req(OP_ENCODE, 8'd6,   16'h0000, 5'd0);
      queue_req(OP_ENCODE, 8'd1,   16'h0000, 5'd0);
      queue_req(OP_ENCODE, 8'd0,   16'h0000, 5'd0);
      queue_req(OP_ENCODE, 8'd4,   16'h0000, 5'd0);
      queue_req(OP_ENCODE, 8'd5,   16'h0000, 5'd0);
      queue_req(OP_ENCODE, 8'd3,   16'h0000, 5'd0);
      queue_req(OP_ENCODE, 8'd7,   16'h0000, 5'd0);
      queue_req(OP_FLUSH,  8'd0,   16'h0000, 5'd0);
      queue_req(OP_FLUSH,  8'd0,   16'h0000, 5'd0);

      // Random: bursts of table writes, then runs of encodes with some flushes and unused opcodes
      n = 0;
      next_drain = DRAIN_EVERY;
      while (n < RANDOM_ITEMS) begin
         if (n >= next_drain) begin
            drain_due = 1'b1;
            next_drain += DRAIN_EVERY;
         end
         k = (written_syms.size() < 24) ? 32 : $urandom_range(1, 6);
         repeat (k) begin
            queue_write(8'($urandom), 16'($urandom), random_length());
            n++;
         end
         k = $urandom_range(5, 40);
         repeat (k) begin
            r = $urandom_range(0, 99);
            if (r < 7) begin
               queue_req(OP_FLUSH, 8'($urandom), 16'($urandom), 5'($urandom));
               n++;
            end else if (r < 9) begin
               queue_req(OP_UNUSED, 8'($urandom), 16'($urandom), 5'($urandom));
            end else begin
               queue_req(OP_ENCODE,
                         8'(written_syms[$urandom_range(0, written_syms.size() - 1)]),
                         16'($urandom), 5'($urandom));
               n++;
            end
         end
      end
      queue_req(OP_FLUSH, 8'd0, 16'h0000, 5'd0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Drain: every request sent, every byte received, then let the block settle
      do @(negedge clock); while (pending_reqs.size() != 0 || req_valid);
      do @(negedge clock); while (expected_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("huffman_code_bit_packer test passed");
      end else begin
         $display("huffman_code_bit_packer test failed");
      end
      $finish;
   end

endmodule
